// ----- rtl/core/ebs_pkg.sv -----
package ebs_pkg;

	localparam int MAX_WORDS = 1048576;
	localparam int POS_W     = $clog2(MAX_WORDS) + 1;
	localparam int IDX_W     = 20;
	localparam int BYTES_W   = 23;
	localparam int BL_W      = 31;
	localparam int SEG_W     = 17;
	localparam int CB_W      = 36;
	localparam int ADDR_W    = 4;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = QPTR_W + 1;

	localparam logic [POS_W-1:0]   MAX_POS   = POS_W'(MAX_WORDS);
	localparam logic [BYTES_W-1:0] MAX_BYTES = BYTES_W'(4 * MAX_WORDS);

	localparam logic [1:0] ST_PRIM = 2'd0;
	localparam logic [1:0] ST_COMP = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;
	localparam logic [1:0] ST_BAD  = 2'd3;

	localparam logic [2:0] PH_LEN = 3'd0;
	localparam logic [2:0] PH_HDR = 3'd1;
	localparam logic [2:0] PH_TAG = 3'd2;
	localparam logic [2:0] PH_SEG = 3'd3;
	localparam logic [2:0] PH_PAD = 3'd4;

	localparam logic [5:0] TY_BANK_A = 6'h0e;
	localparam logic [5:0] TY_BANK_B = 6'h10;
	localparam logic [5:0] TY_COMP   = 6'h0f;

	localparam logic [1:0] REG_FRAG_TAG = 2'd0;
	localparam logic [1:0] REG_BANK_TAG = 2'd1;
	localparam logic [1:0] REG_BANK_NUM = 2'd2;

	typedef struct packed {
		logic [1:0]         status;
		logic [BYTES_W-1:0] bytes;
		logic [IDX_W-1:0]   idx;
	} result_t;

	function automatic logic [POS_W-1:0] clamp_pos(input logic [32:0] p);
		logic [POS_W-1:0] r;
		if (p > 33'(MAX_WORDS)) begin
			r = MAX_POS;
		end else begin
			r = p[POS_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/event_bank_search_unit.sv -----
// Searches one event buffer, one 32-bit word per beat, for a data bank with a given tag and
// number inside a fragment bank with a given tag, and gives exactly one result beat per event
// (found primitive, found composite, not found or malformed) on the word that decides it.
// An input beat is accepted whenever s_tready is high; a word is registered, parsed against
// the header state in the next cycle, and its result is pushed into the output queue.
// Results wait in a four-entry output queue; s_tready drops only while that queue, counting
// the word in flight, is full. Words after the decision are skipped up to tlast. Registers:
// fragment_tag at 0x0, bank_tag at 0x4, bank_number at 0x8; write them between events.
module event_bank_search_unit
	import ebs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [31:0]        s_tdata,   // data_word
	input  logic               s_tlast,   // last_word
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [47:0]        m_tdata,   // data_index[19:0], byte_count[42:20], zero fill
	output logic [1:0]         m_tuser,   // search_status
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [15:0] frag_tag_q;
	logic [15:0] bank_tag_q;
	logic [7:0]  bank_num_q;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic        last_s1;

	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] end_q, end_d;
	logic [POS_W-1:0] nhp_q, nhp_d;
	logic [BL_W-1:0]  bl_q, bl_d;
	logic [SEG_W-1:0] seg_q, seg_d;
	logic             rf_q, rf_d;
	logic [2:0]       phase_q, phase_d;
	logic             done_q, done_d;

	logic               give;
	logic [1:0]         res_st;
	logic [IDX_W-1:0]   res_idx;
	logic [BYTES_W-1:0] res_bytes;

	logic [15:0]        w_tag;
	logic [5:0]         w_type;
	logic [7:0]         w_num;
	logic               len_bad;
	logic [POS_W-1:0]   end_new;
	logic [POS_W-1:0]   pos_p1;
	logic               idx_bad;
	logic [POS_W-1:0]   nhp_plus2;
	logic [POS_W-1:0]   nhp_skip;
	logic [SEG_W-1:0]   seg_new;
	logic [POS_W-1:0]   nhp_seg;
	logic [BL_W-1:0]    bm1;
	logic [BYTES_W-1:0] prim_bytes;
	logic signed [CB_W-1:0] cw;
	logic signed [CB_W-1:0] cb;
	logic [BYTES_W-1:0] comp_bytes;

	result_t             q_mem [QDEPTH];
	logic [QPTR_W-1:0]   head_q, tail_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                push, pop;
	result_t             head_res;

	logic cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frag_tag_q <= '0;
			bank_tag_q <= '0;
			bank_num_q <= '0;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_FRAG_TAG: frag_tag_q <= pwdata[15:0];
				REG_BANK_TAG: bank_tag_q <= pwdata[15:0];
				REG_BANK_NUM: bank_num_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_FRAG_TAG: prdata = {16'd0, frag_tag_q};
			REG_BANK_TAG: prdata = {16'd0, bank_tag_q};
			REG_BANK_NUM: prdata = {24'd0, bank_num_q};
			default:      prdata = '0;
		endcase
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_tvalid & s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			word_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	assign w_tag     = word_s1[31:16];
	assign w_type    = word_s1[13:8];
	assign w_num     = word_s1[7:0];
	assign len_bad   = word_s1 >= 32'(MAX_WORDS);
	assign end_new   = POS_W'(word_s1) + POS_W'(1);
	assign pos_p1    = pos_q + POS_W'(1);
	assign idx_bad   = pos_p1 >= MAX_POS;
	assign nhp_plus2 = clamp_pos(33'(nhp_q) + 33'd2);
	assign nhp_skip  = clamp_pos(33'(nhp_q) + 33'(bl_q) + 33'd1);
	assign seg_new   = SEG_W'(word_s1[15:0]) + SEG_W'(1);
	assign nhp_seg   = clamp_pos(33'(pos_q) + 33'(seg_new) + 33'd1);
	assign bm1       = bl_q - BL_W'(1);
	assign prim_bytes = (bm1 > BL_W'(MAX_WORDS)) ? MAX_BYTES : BYTES_W'({bm1, 2'b00});
	assign cw = $signed(CB_W'(bl_q)) + $signed(CB_W'(1)) - $signed(CB_W'(seg_q))
		- $signed(CB_W'(4));
	assign cb = (cw <<< 2) - $signed(CB_W'(word_s1[15:14]));
	assign comp_bytes = (cb > $signed(CB_W'(4 * MAX_WORDS))) ? MAX_BYTES : cb[BYTES_W-1:0];

	always_comb begin
		phase_d   = phase_q;
		end_d     = end_q;
		nhp_d     = nhp_q;
		bl_d      = bl_q;
		seg_d     = seg_q;
		rf_d      = rf_q;
		done_d    = done_q;
		pos_d     = pos_q;
		give      = 1'b0;
		res_st    = ST_NONE;
		res_idx   = '0;
		res_bytes = '0;
		if (!done_q) begin
			if (pos_q >= MAX_POS) begin
				give   = 1'b1;
				res_st = ST_BAD;
			end else begin
				unique case (phase_q)
					PH_LEN: begin
						if (len_bad) begin
							give   = 1'b1;
							res_st = ST_BAD;
						end else begin
							end_d = end_new;
							nhp_d = POS_W'(2);
							if (POS_W'(2) >= end_new) begin
								give = 1'b1;
							end else begin
								phase_d = PH_HDR;
							end
						end
					end
					PH_HDR: begin
						if (pos_q == nhp_q) begin
							bl_d = word_s1[BL_W-1:0];
							if (word_s1 == 32'd0 || word_s1[31]) begin
								give   = 1'b1;
								res_st = ST_BAD;
							end else begin
								phase_d = PH_TAG;
							end
						end
					end
					PH_TAG: begin
						if (w_type == TY_BANK_A || w_type == TY_BANK_B) begin
							rf_d  = (w_tag == frag_tag_q);
							nhp_d = nhp_plus2;
							if (nhp_plus2 >= end_q) begin
								give = 1'b1;
							end else begin
								phase_d = PH_HDR;
							end
						end else if (rf_q && w_tag == bank_tag_q && w_num == bank_num_q) begin
							if (w_type != TY_COMP) begin
								give = 1'b1;
								if (idx_bad) begin
									res_st = ST_BAD;
								end else begin
									res_st    = ST_PRIM;
									res_idx   = pos_p1[IDX_W-1:0];
									res_bytes = prim_bytes;
								end
							end else begin
								nhp_d   = pos_p1;
								phase_d = PH_SEG;
							end
						end else begin
							nhp_d = nhp_skip;
							if (nhp_skip >= end_q) begin
								give = 1'b1;
							end else begin
								phase_d = PH_HDR;
							end
						end
					end
					PH_SEG: begin
						if (pos_q == nhp_q) begin
							seg_d   = seg_new;
							nhp_d   = nhp_seg;
							phase_d = PH_PAD;
						end
					end
					PH_PAD: begin
						if (pos_q == nhp_q) begin
							give = 1'b1;
							if (cb[CB_W-1] || idx_bad) begin
								res_st = ST_BAD;
							end else begin
								res_st    = ST_COMP;
								res_idx   = pos_p1[IDX_W-1:0];
								res_bytes = comp_bytes;
							end
						end
					end
					default: phase_d = PH_LEN;
				endcase
			end
			if (!give && last_s1) begin
				give   = 1'b1;
				res_st = ST_BAD;
			end
		end
		if (give) begin
			done_d = 1'b1;
		end
		if (pos_q < MAX_POS) begin
			pos_d = pos_p1;
		end
		if (last_s1) begin
			pos_d   = '0;
			end_d   = '0;
			nhp_d   = POS_W'(2);
			bl_d    = '0;
			seg_d   = '0;
			rf_d    = 1'b0;
			phase_d = PH_LEN;
			done_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			end_q   <= '0;
			nhp_q   <= POS_W'(2);
			bl_q    <= '0;
			seg_q   <= '0;
			rf_q    <= 1'b0;
			phase_q <= PH_LEN;
			done_q  <= 1'b0;
		end else if (valid_s1) begin
			pos_q   <= pos_d;
			end_q   <= end_d;
			nhp_q   <= nhp_d;
			bl_q    <= bl_d;
			seg_q   <= seg_d;
			rf_q    <= rf_d;
			phase_q <= phase_d;
			done_q  <= done_d;
		end
	end

	// result queue
	assign push     = valid_s1 & give;
	assign pop      = m_tvalid & m_tready;
	assign s_tready = (cnt_q + QCNT_W'(valid_s1)) < QCNT_W'(QDEPTH);
	assign m_tvalid = cnt_q != '0;
	assign head_res = q_mem[head_q];
	assign m_tdata  = {5'd0, head_res.bytes, head_res.idx};
	assign m_tuser  = head_res.status;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[tail_q] <= '{status: res_st, bytes: res_bytes, idx: res_idx};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_q + QPTR_W'(1);
			end
			if (pop) begin
				head_q <= head_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (cnt_q < QCNT_W'(QDEPTH)))
		else $error("result queue overflow");

	a_one_per_event: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !last_s1) |=> (done_q && !push))
		else $error("second result within one event");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q <= MAX_POS) && (nhp_q <= MAX_POS) && (end_q <= MAX_POS))
		else $error("position state out of range");

	a_found_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(push && (res_st == ST_NONE || res_st == ST_BAD)) |-> (res_idx == '0 && res_bytes == '0))
		else $error("empty result carries data");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top
	import ebs_pkg::*;
();

	localparam int         WATCHDOG_CYCLES = 3000;
	localparam logic [5:0] TY_PLAIN        = 6'h01;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;   // data_index[19:0], byte_count[42:20], zero fill
	logic [1:0]  m_tuser;   // search_status
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	event_bank_search_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// register copies
	logic [15:0] cfg_frag = '0;
	logic [15:0] cfg_tag  = '0;
	logic [7:0]  cfg_num  = '0;

	// per-event search state
	longint     ev_pos, ev_end, ev_next, ev_blen, ev_seg;
	logic       ev_frag_ok, ev_done;
	logic [2:0] ev_phase;

	result_t     pending[$];
	logic [31:0] ev_q[$];
	int          err_cnt      = 0;
	int          quiet_cycles = 0;
	int          words_sent   = 0;
	bit          gaps_on      = 1'b1;
	bit          stalls_on    = 1'b1;

	task automatic flag_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10) begin
			$display("%s", msg);
		end
	endtask

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 85) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 24);
	endfunction

	task automatic clear_event();
		ev_pos     = 0;
		ev_end     = 0;
		ev_next    = 2;
		ev_blen    = 0;
		ev_seg     = 0;
		ev_frag_ok = 1'b0;
		ev_phase   = PH_LEN;
		ev_done    = 1'b0;
	endtask

	function automatic longint pos_limit(input longint p);
		return (p > MAX_WORDS) ? longint'(MAX_WORDS) : p;
	endfunction

	task automatic post_result(input logic [1:0] st, input longint at, input longint nb);
		result_t r;
		if ((st == ST_PRIM || st == ST_COMP) && (nb < 0 || at >= MAX_WORDS)) begin
			st = ST_BAD;
		end
		if (st == ST_NONE || st == ST_BAD) begin
			at = 0;
			nb = 0;
		end
		if (nb > 4 * MAX_WORDS) begin
			nb = 4 * MAX_WORDS;
		end
		r.status = st;
		r.idx    = at[IDX_W-1:0];
		r.bytes  = nb[BYTES_W-1:0];
		pending.push_back(r);
		ev_done = 1'b1;
	endtask

	// advance the search by one accepted word
	task automatic search_step(input logic [31:0] w, input logic last);
		longint      len, pad, wc;
		logic [15:0] tg;
		logic [5:0]  ty;
		logic [7:0]  nm;
		tg = w[31:16];
		ty = w[13:8];
		nm = w[7:0];
		if (!ev_done) begin
			if (ev_pos >= MAX_WORDS) begin
				post_result(ST_BAD, 0, 0);
			end else begin
				case (ev_phase)
					PH_LEN: begin
						len = w;
						len = len + 1;
						if (len > MAX_WORDS) begin
							post_result(ST_BAD, 0, 0);
						end else begin
							ev_end  = len;
							ev_next = 2;
							if (ev_next >= ev_end) begin
								post_result(ST_NONE, 0, 0);
							end else begin
								ev_phase = PH_HDR;
							end
						end
					end
					PH_HDR: begin
						if (ev_pos == ev_next) begin
							ev_blen = w;
							if (w == 0 || w[31]) begin
								post_result(ST_BAD, 0, 0);
							end else begin
								ev_phase = PH_TAG;
							end
						end
					end
					PH_TAG: begin
						if (ty == TY_BANK_A || ty == TY_BANK_B) begin
							ev_frag_ok = (tg == cfg_frag);
							ev_next    = pos_limit(ev_next + 2);
						end else if (ev_frag_ok && tg == cfg_tag && nm == cfg_num) begin
							if (ty != TY_COMP) begin
								post_result(ST_PRIM, ev_pos + 1, (ev_blen - 1) * 4);
							end else begin
								ev_next  = pos_limit(ev_pos + 1);
								ev_phase = PH_SEG;
							end
						end else begin
							ev_next = pos_limit(ev_next + ev_blen + 1);
						end
						if (!ev_done && ev_phase == PH_TAG) begin
							if (ev_next >= ev_end) begin
								post_result(ST_NONE, 0, 0);
							end else begin
								ev_phase = PH_HDR;
							end
						end
					end
					PH_SEG: begin
						if (ev_pos == ev_next) begin
							ev_seg   = w[15:0];
							ev_seg   = ev_seg + 1;
							ev_next  = pos_limit(ev_pos + ev_seg + 1);
							ev_phase = PH_PAD;
						end
					end
					default: begin
						if (ev_pos == ev_next) begin
							pad = w[15:14];
							wc  = ev_blen + 1 - ev_seg - 4;
							post_result(ST_COMP, ev_pos + 1, wc * 4 - pad);
						end
					end
				endcase
			end
			if (!ev_done && last) begin
				post_result(ST_BAD, 0, 0);
			end
		end
		if (ev_pos < MAX_WORDS) begin
			ev_pos++;
		end
		if (last) begin
			clear_event();
		end
	endtask

	task automatic send_word(input logic [31:0] w, input logic last);
		int g;
		if (gaps_on && $urandom_range(0, 99) < 35) begin
			g = gap_len();
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		search_step(w, last);
	endtask

	task automatic send_event();
		foreach (ev_q[i]) begin
			send_word(ev_q[i], i == ev_q.size() - 1);
		end
		words_sent += ev_q.size();
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		logic [31:0] want;
		want = (idx == REG_BANK_NUM) ? {24'd0, val[7:0]} : {16'd0, val[15:0]};
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_FRAG_TAG: cfg_frag = val[15:0];
			REG_BANK_TAG: cfg_tag  = val[15:0];
			default:      cfg_num  = val[7:0];
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			flag_error($sformatf("register %0d read: expected %h got %h", idx, want, prdata));
		end
	endtask

	task automatic set_config(input logic [15:0] frag, input logic [15:0] tag,
			input logic [7:0] num);
		drain();
		reg_write(REG_FRAG_TAG, {16'($urandom), frag});
		reg_write(REG_BANK_TAG, {16'($urandom), tag});
		reg_write(REG_BANK_NUM, {24'($urandom), num});
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// event buffer construction
	task automatic ev_begin();
		ev_q.delete();
		ev_q.push_back(32'd0);
		ev_q.push_back(32'($urandom));
	endtask

	function automatic int open_frag(input logic [15:0] tag, input logic [5:0] ty);
		int at;
		at = ev_q.size();
		ev_q.push_back(32'd0);
		ev_q.push_back({tag, 2'($urandom), ty, 8'($urandom)});
		return at;
	endfunction

	task automatic close_frag(input int at);
		ev_q[at] = ev_q.size() - at - 1;
	endtask

	task automatic add_prim(input logic [15:0] tag, input logic [7:0] num, input int d);
		logic [5:0] ty;
		ty = 6'($urandom);
		if (ty == TY_BANK_A || ty == TY_BANK_B || ty == TY_COMP) begin
			ty = TY_PLAIN;
		end
		ev_q.push_back(d + 1);
		ev_q.push_back({tag, 2'($urandom), ty, num});
		repeat (d) ev_q.push_back($urandom);
	endtask

	task automatic add_comp(input logic [15:0] tag, input logic [7:0] num,
			input logic [15:0] seg_len, input int seg_words, input int d, input logic [1:0] pad);
		ev_q.push_back(seg_words + d + 4);
		ev_q.push_back({tag, 2'($urandom), TY_COMP, num});
		ev_q.push_back({16'($urandom), seg_len});
		repeat (seg_words) ev_q.push_back($urandom);
		ev_q.push_back(d + 1);
		ev_q.push_back({16'($urandom), pad, 14'($urandom)});
		repeat (d) ev_q.push_back($urandom);
	endtask

	task automatic add_random_bank(input bit nest_ok);
		int          r, k, at;
		logic [15:0] tg;
		logic [7:0]  nm;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 2) == 0) begin
			tg = cfg_tag;
			nm = cfg_num;
		end else if ($urandom_range(0, 1) == 0) begin
			tg = cfg_tag;
			nm = 8'($urandom);
		end else begin
			tg = 16'($urandom);
			nm = 8'($urandom);
		end
		if (nest_ok && r < 15) begin
			at = open_frag(($urandom_range(0, 1) == 0) ? cfg_frag : 16'($urandom),
				($urandom_range(0, 1) == 0) ? TY_BANK_A : TY_BANK_B);
			add_random_bank(1'b0);
			close_frag(at);
		end else if (r < 45) begin
			k = $urandom_range(0, 3);
			add_comp(tg, nm, ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(k), k,
				$urandom_range(0, 4), 2'($urandom));
		end else begin
			add_prim(tg, nm, $urandom_range(0, 4));
		end
	endtask

	task automatic build_random_event();
		int at, r;
		ev_begin();
		repeat ($urandom_range(1, 3)) begin
			at = open_frag(($urandom_range(0, 9) < 7) ? cfg_frag : 16'($urandom),
				($urandom_range(0, 1) == 0) ? TY_BANK_A : TY_BANK_B);
			repeat ($urandom_range(1, 3)) add_random_bank(1'b1);
			close_frag(at);
		end
		ev_q[0] = ev_q.size() - 1;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			ev_q[0] = $urandom;
		end else if (r < 12) begin
			ev_q[0] = $urandom_range(0, ev_q.size() + 2);
		end else if (r < 20) begin
			ev_q[$urandom_range(2, ev_q.size() - 1)] = $urandom;
		end else if (r < 27) begin
			ev_q = ev_q[0:$urandom_range(0, ev_q.size() - 2)];
		end else if (r < 33) begin
			repeat ($urandom_range(1, 4)) ev_q.push_back($urandom);
		end
	endtask

	task automatic test_directed_cases();
		int at;
		set_config(16'h1234, 16'hABCD, 8'h5A);
		ev_q = '{32'd1, 32'($urandom)};
		send_event();
		ev_q = '{32'hFFFF_FFFF, 32'($urandom)};
		send_event();
		ev_q = '{32'h0010_0000};
		send_event();
		ev_q = '{32'h000F_FFFF, 32'($urandom)};
		send_event();
		ev_q = '{32'd2, 32'($urandom), 32'd0};
		send_event();
		ev_q = '{32'd2, 32'($urandom), 32'h8000_0000};
		send_event();
		ev_q = '{32'd3, 32'($urandom), 32'h7FFF_FFFF, {16'h0001, 2'b00, TY_PLAIN, 8'h00}};
		send_event();
		ev_begin();
		at = open_frag(cfg_frag, TY_BANK_A);
		ev_q.push_back(32'h7FFF_FFFF);
		ev_q.push_back({cfg_tag, 2'b11, 6'h3F, cfg_num});
		close_frag(at);
		ev_q[0] = ev_q.size() - 1;
		send_event();
		ev_begin();
		at = open_frag(cfg_frag, TY_BANK_B);
		add_comp(cfg_tag, cfg_num, 16'd1, 1, 2, 2'd3);
		close_frag(at);
		ev_q[0] = ev_q.size() - 1;
		send_event();
		ev_begin();
		at = open_frag(cfg_frag, TY_BANK_A);
		add_comp(cfg_tag, cfg_num, 16'd0, 0, 0, 2'd2);
		close_frag(at);
		ev_q[0] = ev_q.size() - 1;
		send_event();
		ev_begin();
		at = open_frag(~cfg_frag, TY_BANK_A);
		add_prim(cfg_tag, cfg_num, 0);
		close_frag(at);
		ev_q[0] = ev_q.size() - 1;
		send_event();
	endtask

	task automatic run_phase(input logic [15:0] frag, input logic [15:0] tag,
			input logic [7:0] num, input bit idle, input int n_words);
		set_config(frag, tag, num);
		gaps_on    = idle;
		stalls_on  = idle;
		words_sent = 0;
		while (words_sent < n_words) begin
			build_random_event();
			send_event();
		end
	endtask

	task automatic test_random_traffic();
		run_phase(16'h0000, 16'h0000, 8'h00, 1'b1, 360);
		run_phase(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 360);
		run_phase(16'($urandom), 16'($urandom), 8'($urandom), 1'b0, 280);
		run_phase(16'($urandom), 16'($urandom), 8'($urandom), 1'b1, 400);
		run_phase(16'hFFFF, 16'h0000, 8'h80, 1'b1, 350);
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending.size() == 0) begin
				flag_error($sformatf("unexpected result: status %0d index %0d bytes %0d",
					m_tuser, m_tdata[19:0], m_tdata[42:20]));
			end else begin
				want = pending.pop_front();
				if (want.status !== m_tuser || want.idx !== m_tdata[19:0] ||
						want.bytes !== m_tdata[42:20]) begin
					flag_error($sformatf(
						"mismatch: expected status %0d index %0d bytes %0d, got %0d %0d %0d",
						want.status, want.idx, want.bytes,
						m_tuser, m_tdata[19:0], m_tdata[42:20]));
				end
			end
		end
	end

	always @(posedge clk) begin : ready_gen
		int stall_left;
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (stalls_on && $urandom_range(0, 99) < 25) begin
			stall_left = gap_len() - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		clear_event();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_traffic();
		drain();
		if (err_cnt == 0 && pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/ebs_pkg.sv
rtl/core/event_bank_search_unit.sv
tb/tb_top.sv
